// ===== src/disk_service_request_status_defines.svh =====
// assertion macros for the disk service request block
`ifndef DISK_SERVICE_REQUEST_STATUS_DEFINES_SVH
`define DISK_SERVICE_REQUEST_STATUS_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DSRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsrs assertion failed");

// next-cycle implication
`define DSRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsrs assertion failed");

`endif

// ===== src/dsrs_pkg.sv =====
package dsrs_pkg;

	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 11;

	typedef logic [3:0] status_t;

	localparam status_t ST_OK        = 4'd0;
	localparam status_t ST_BADCMD    = 4'd1;
	localparam status_t ST_WPROT     = 4'd2;
	localparam status_t ST_NOTFOUND  = 4'd3;
	localparam status_t ST_OVERRUN   = 4'd4;
	localparam status_t ST_DMABOUND  = 4'd5;
	localparam status_t ST_CRC       = 4'd6;
	localparam status_t ST_CTRL      = 4'd7;
	localparam status_t ST_SEEK      = 4'd8;
	localparam status_t ST_TIMEOUT   = 4'd9;
	localparam status_t ST_RESETFAIL = 4'd10;

	localparam logic [7:0] FN_RESET  = 8'h00;
	localparam logic [7:0] FN_STATUS = 8'h01;
	localparam logic [7:0] FN_READ   = 8'h02;
	localparam logic [7:0] FN_VERIFY = 8'h04;
	localparam logic [7:0] FN_PARAMS = 8'h08;

	localparam logic [2:0] OC_OK        = 3'd0;
	localparam logic [2:0] OC_TIMEOUT   = 3'd1;
	localparam logic [2:0] OC_RECAL     = 3'd2;
	localparam logic [2:0] OC_SEEK      = 3'd3;
	localparam logic [2:0] OC_SHORT     = 3'd4;
	localparam logic [2:0] OC_RESETFAIL = 3'd5;

	localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_COUNT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_COUNT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TRACK_COUNT  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPT          = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_BYTES = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_TYPE   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_PARAMS_EN    = 3'd6;

	typedef struct packed {
		logic [2:0]  drive_count;
		logic [1:0]  head_count;
		logic [10:0] track_count;
		logic [5:0]  sectors_per_track;
		logic [10:0] sector_bytes;
		logic [7:0]  drive_type_code;
		logic        get_params_enable;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		drive_count:       3'd2,
		head_count:        2'd2,
		track_count:       11'd80,
		sectors_per_track: 6'd18,
		sector_bytes:      11'd512,
		drive_type_code:   8'd4,
		get_params_enable: 1'b1
	};

	typedef struct packed {
		logic [7:0]  function_code;
		logic [7:0]  sector_count;
		logic [7:0]  drive_number;
		logic [7:0]  head_number;
		logic [15:0] cyl_sector_word;
		logic [15:0] buffer_offset;
		logic [2:0]  step_outcome;
		logic [7:0]  status_zero;
		logic [7:0]  status_one;
		logic [7:0]  status_two;
	} req_t;

	typedef struct packed {
		status_t     status_code;
		logic [7:0]  transferred_count;
		logic        carry_flag;
		logic        params_valid;
		logic [15:0] geom_cx;
		logic [15:0] geom_dx;
		logic [7:0]  geom_bx;
	} rsp_t;

endpackage

// ===== src/dsrs_ctrl_status.sv =====
module dsrs_ctrl_status import dsrs_pkg::*; (
	input  logic [2:0] step_outcome,
	input  logic       is_verify,
	input  logic [7:0] status_zero,
	input  logic [7:0] status_one,
	input  logic [7:0] status_two,
	output status_t    ctrl_status
);

	status_t oc_status;
	status_t st_status;

	always_comb begin
		unique case (step_outcome)
			OC_OK:        oc_status = ST_OK;
			OC_TIMEOUT:   oc_status = ST_TIMEOUT;
			OC_RECAL:     oc_status = ST_RESETFAIL;
			OC_SEEK:      oc_status = ST_SEEK;
			OC_SHORT:     oc_status = is_verify ? ST_OK : ST_CTRL;
			OC_RESETFAIL: oc_status = ST_RESETFAIL;
			default:      oc_status = ST_TIMEOUT;
		endcase
	end

	// result bytes by priority, only read uses them
	always_comb begin
		priority if ((status_zero & 8'hC0) == 8'h00 && (status_one & 8'h37) == 8'h00 &&
				(status_two & 8'h33) == 8'h00) begin
			st_status = ST_OK;
		end else if (status_one[1]) begin
			st_status = ST_WPROT;
		end else if (status_one[4]) begin
			st_status = ST_OVERRUN;
		end else if (status_one[0] || status_one[2] || status_two[0]) begin
			st_status = ST_NOTFOUND;
		end else if (status_one[5] || status_two[5]) begin
			st_status = ST_CRC;
		end else if (status_two[4] || status_two[1] || status_zero[4]) begin
			st_status = ST_SEEK;
		end else begin
			st_status = ST_CTRL;
		end
	end

	assign ctrl_status = (oc_status != ST_OK || is_verify) ? oc_status : st_status;

endmodule

// ===== src/dsrs_eval.sv =====
module dsrs_eval import dsrs_pkg::*; (
	input  req_t    req,
	input  cfg_t    cfg,
	input  status_t last_status,
	output rsp_t    rsp,
	output logic    update_last
);

	logic [5:0]  sector;
	logic [9:0]  cyl;
	logic [8:0]  run_end;
	logic [18:0] dma_bytes;
	logic [16:0] dma_sum;
	status_t     chk_status;
	status_t     ctrl_status;
	status_t     xfer_status;
	logic        is_verify;
	logic [10:0] max_cyl;
	logic [7:0]  last_head;
	logic        params_ok;

	assign sector    = req.cyl_sector_word[5:0];
	assign cyl       = {req.cyl_sector_word[7:6], req.cyl_sector_word[15:8]};
	assign run_end   = {3'b000, sector} + {1'b0, req.sector_count} - 9'd1;
	assign dma_bytes = {11'd0, req.sector_count} * {8'd0, cfg.sector_bytes};
	assign dma_sum   = {1'b0, req.buffer_offset} + {1'b0, dma_bytes[15:0]};
	assign is_verify = (req.function_code == FN_VERIFY);

	// geometry and buffer checks, dma wrap only for read
	always_comb begin
		priority if ({5'd0, cfg.drive_count} <= req.drive_number ||
				req.sector_count == 8'd0) begin
			chk_status = ST_BADCMD;
		end else if ({6'd0, cfg.head_count} <= req.head_number ||
				cfg.track_count <= {1'b0, cyl} || sector == 6'd0 ||
				sector > cfg.sectors_per_track ||
				run_end > {3'b000, cfg.sectors_per_track}) begin
			chk_status = ST_NOTFOUND;
		end else if (!is_verify && dma_sum[16]) begin
			chk_status = ST_DMABOUND;
		end else begin
			chk_status = ST_OK;
		end
	end

	dsrs_ctrl_status u_ctrl_status (
		.step_outcome (req.step_outcome),
		.is_verify    (is_verify),
		.status_zero  (req.status_zero),
		.status_one   (req.status_one),
		.status_two   (req.status_two),
		.ctrl_status  (ctrl_status)
	);

	assign xfer_status = (chk_status != ST_OK) ? chk_status : ctrl_status;
	assign max_cyl     = cfg.track_count - 11'd1;
	assign last_head   = {6'd0, cfg.head_count} - 8'd1;
	assign params_ok   = cfg.get_params_enable &&
		({5'd0, cfg.drive_count} > req.drive_number);
	assign update_last = (req.function_code != FN_STATUS);

	always_comb begin
		rsp = '0;
		unique case (req.function_code)
			FN_RESET: begin
				rsp.status_code = (req.step_outcome == OC_OK) ? ST_OK : ST_RESETFAIL;
			end
			FN_STATUS: begin
				rsp.status_code       = last_status;
				rsp.transferred_count = req.sector_count;
			end
			FN_READ, FN_VERIFY: begin
				rsp.status_code = xfer_status;
				if (xfer_status == ST_OK) begin
					rsp.transferred_count = req.sector_count;
				end
			end
			FN_PARAMS: begin
				if (params_ok) begin
					rsp.params_valid = 1'b1;
					rsp.geom_cx      = {max_cyl[7:0], max_cyl[9:8], cfg.sectors_per_track};
					rsp.geom_dx      = {last_head, 5'd0, cfg.drive_count};
					rsp.geom_bx      = cfg.drive_type_code;
				end else begin
					rsp.status_code = ST_BADCMD;
				end
			end
			default: begin
				rsp.status_code = ST_BADCMD;
			end
		endcase
		rsp.carry_flag = update_last && (rsp.status_code != ST_OK);
	end

endmodule

// ===== src/disk_service_request_status.sv =====
// disk service request status
// slave stream: one request per beat, fields in s_axis_tdata; the block
// answers each request with exactly one beat on the master stream.
// configuration: cfg_we with cfg_index and cfg_data writes one geometry
// register at the clock edge; write only while no request is in flight.
// pipeline: an accepted beat is held in the input register and then loaded
// into the result register, which drives m_axis_tvalid.
// throughput: one request per cycle while m_axis_tready is high; the
// request is evaluated in one combinational pass between the two registers,
// and the last status register is updated as the result is loaded, so a
// status query right behind another request sees that request's status.
// stall: when m_axis_tready is low the result register holds and the input
// register still takes one more beat; s_axis_tready falls only when both
// are full.
// reset: arst_n clears both valid flags, loads the default geometry
// (2 drives, 2 heads, 80 cylinders, 18 sectors, 512 bytes, type 4,
// get-parameters enabled) and sets the last status to ok.
`include "disk_service_request_status_defines.svh"

module disk_service_request_status import dsrs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// function_code, sector_count, drive_number, head_number, cyl_sector_word,
	// buffer_offset, step_outcome, status_zero, status_one, status_two, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// status_code, transferred_count, carry_flag, params_valid, geom_cx,
	// geom_dx, geom_bx, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t    cfg_q;
	status_t last_status_q;
	logic    in_valid_s1;
	req_t    req_s1;
	logic    out_valid_s2;
	rsp_t    rsp_s2;
	req_t    req_in;
	rsp_t    rsp;
	logic    update_last;
	logic    advance;

	assign req_in = '{
		function_code:   s_axis_tdata[7:0],
		sector_count:    s_axis_tdata[15:8],
		drive_number:    s_axis_tdata[23:16],
		head_number:     s_axis_tdata[31:24],
		cyl_sector_word: s_axis_tdata[47:32],
		buffer_offset:   s_axis_tdata[63:48],
		step_outcome:    s_axis_tdata[66:64],
		status_zero:     s_axis_tdata[74:67],
		status_one:      s_axis_tdata[82:75],
		status_two:      s_axis_tdata[90:83]
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DRIVE_COUNT:  cfg_q.drive_count       <= cfg_data[2:0];
				CFG_HEAD_COUNT:   cfg_q.head_count        <= cfg_data[1:0];
				CFG_TRACK_COUNT:  cfg_q.track_count       <= cfg_data[10:0];
				CFG_SPT:          cfg_q.sectors_per_track <= cfg_data[5:0];
				CFG_SECTOR_BYTES: cfg_q.sector_bytes      <= cfg_data[10:0];
				CFG_DRIVE_TYPE:   cfg_q.drive_type_code   <= cfg_data[7:0];
				CFG_PARAMS_EN:    cfg_q.get_params_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance       = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1 <= req_in;
		end
	end

	dsrs_eval u_eval (
		.req         (req_s1),
		.cfg         (cfg_q),
		.last_status (last_status_q),
		.rsp         (rsp),
		.update_last (update_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2  <= 1'b0;
			last_status_q <= ST_OK;
		end else begin
			if (!out_valid_s2 || m_axis_tready) begin
				out_valid_s2 <= in_valid_s1;
			end
			if (advance && update_last) begin
				last_status_q <= rsp.status_code;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {2'b00, rsp_s2.geom_bx, rsp_s2.geom_dx, rsp_s2.geom_cx,
		rsp_s2.params_valid, rsp_s2.carry_flag, rsp_s2.transferred_count,
		rsp_s2.status_code};

	`DSRS_ASSERT_IMP(a_carry_status, out_valid_s2 && rsp_s2.carry_flag, rsp_s2.status_code != ST_OK)
	`DSRS_ASSERT_IMP(a_params_ok, out_valid_s2 && rsp_s2.params_valid,
		rsp_s2.status_code == ST_OK && rsp_s2.transferred_count == 8'd0)
	`DSRS_ASSERT_NXT(a_accept_fills, s_axis_tvalid && s_axis_tready, in_valid_s1)
	`DSRS_ASSERT_NXT(a_last_status, advance && update_last, last_status_q == rsp_s2.status_code)

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dsrs_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 330;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	req_t        pending_requests[$];
	rsp_t        expected_replies[$];
	cfg_t        geom      = CFG_RESET;
	status_t     last_stat = ST_OK;
	int unsigned idle_pct  = 0;
	int unsigned src_gap   = 0;
	int unsigned sink_gap  = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches   = 0;
	logic        req_hs = 1'b0;

	disk_service_request_status i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic status_t outcome_to_status(logic [2:0] oc, bit verify);
		case (oc)
			OC_OK: return ST_OK;
			OC_RECAL, OC_RESETFAIL: return ST_RESETFAIL;
			OC_SEEK: return ST_SEEK;
			OC_SHORT: return verify ? ST_OK : ST_CTRL;
			default: return ST_TIMEOUT;
		endcase
	endfunction

	function automatic status_t check_request(req_t r, bit with_dma);
		logic [9:0]  cyl;
		logic [5:0]  sec;
		logic [31:0] bytes;
		logic [16:0] span;
		cyl = {r.cyl_sector_word[7:6], r.cyl_sector_word[15:8]};
		sec = r.cyl_sector_word[5:0];
		if (r.drive_number >= geom.drive_count || r.sector_count == 0)
			return ST_BADCMD;
		if (r.head_number >= geom.head_count || cyl >= geom.track_count || sec == 0 ||
				sec > geom.sectors_per_track ||
				int'(sec) + int'(r.sector_count) - 1 > int'(geom.sectors_per_track))
			return ST_NOTFOUND;
		bytes = 32'(r.sector_count) * 32'(geom.sector_bytes);
		span = 17'(r.buffer_offset) + 17'(bytes[15:0]);
		if (with_dma && span[16])
			return ST_DMABOUND;
		return ST_OK;
	endfunction

	// expected reply for one request, updates the last status unless it is a status query
	function automatic rsp_t serve_request(req_t r);
		rsp_t        o;
		status_t     st;
		logic [10:0] maxcyl;
		o = '0;
		st = ST_OK;
		case (r.function_code)
			FN_RESET: st = (r.step_outcome == OC_OK) ? ST_OK : ST_RESETFAIL;
			FN_STATUS: begin
				o.status_code = last_stat;
				o.transferred_count = r.sector_count;
				return o;
			end
			FN_READ: begin
				st = check_request(r, 1'b1);
				if (st == ST_OK)
					st = outcome_to_status(r.step_outcome, 1'b0);
				if (st == ST_OK && !((r.status_zero & 8'hC0) == 0 &&
						(r.status_one & 8'h37) == 0 && (r.status_two & 8'h33) == 0)) begin
					if (r.status_one[1])
						st = ST_WPROT;
					else if (r.status_one[4])
						st = ST_OVERRUN;
					else if ((r.status_one & 8'h05) != 0 || r.status_two[0])
						st = ST_NOTFOUND;
					else if (r.status_one[5] || r.status_two[5])
						st = ST_CRC;
					else if ((r.status_two & 8'h12) != 0 || r.status_zero[4])
						st = ST_SEEK;
					else
						st = ST_CTRL;
				end
				if (st == ST_OK)
					o.transferred_count = r.sector_count;
			end
			FN_VERIFY: begin
				st = check_request(r, 1'b0);
				if (st == ST_OK)
					st = outcome_to_status(r.step_outcome, 1'b1);
				if (st == ST_OK)
					o.transferred_count = r.sector_count;
			end
			FN_PARAMS: begin
				if (!geom.get_params_enable || r.drive_number >= geom.drive_count) begin
					st = ST_BADCMD;
				end else begin
					maxcyl = geom.track_count - 11'd1;
					o.geom_cx = {maxcyl[7:0], maxcyl[9:8], geom.sectors_per_track};
					o.geom_dx = {8'(geom.head_count) - 8'd1, 5'd0, geom.drive_count};
					o.geom_bx = geom.drive_type_code;
					o.params_valid = 1'b1;
				end
			end
			default: st = ST_BADCMD;
		endcase
		last_stat = st;
		o.status_code = st;
		o.carry_flag = (st != ST_OK);
		return o;
	endfunction

	// mostly well-formed reads and verifies against the current geometry
	function automatic req_t make_request();
		req_t        r;
		logic [95:0] raw;
		int unsigned pick, sec, cyl, cyl_lim;
		raw = {$urandom, $urandom, $urandom};
		r = raw[90:0];
		pick = $urandom_range(99);
		if (pick < 8)
			return r;
		if (pick < 45)
			r.function_code = FN_READ;
		else if (pick < 65)
			r.function_code = FN_VERIFY;
		else if (pick < 73)
			r.function_code = FN_STATUS;
		else if (pick < 81)
			r.function_code = FN_RESET;
		else if (pick < 92)
			r.function_code = FN_PARAMS;
		if (r.function_code == FN_PARAMS)
			r.drive_number = 8'($urandom_range(4));
		if ((r.function_code == FN_READ || r.function_code == FN_VERIFY) &&
				$urandom_range(9) != 0 && geom.drive_count != 0 && geom.head_count != 0 &&
				geom.track_count != 0 && geom.sectors_per_track != 0) begin
			cyl_lim = (geom.track_count > 1024) ? 1024 : geom.track_count;
			cyl = $urandom_range(cyl_lim - 1);
			sec = $urandom_range(geom.sectors_per_track, 1);
			r.drive_number = 8'($urandom_range(geom.drive_count - 1));
			r.head_number = 8'($urandom_range(geom.head_count - 1));
			r.sector_count = 8'($urandom_range(geom.sectors_per_track - sec + 1, 1));
			r.cyl_sector_word = {cyl[7:0], cyl[9:8], sec[5:0]};
			if ($urandom_range(1))
				r.buffer_offset = 16'($urandom_range(16'h3FFF));
		end
		r.step_outcome = ($urandom_range(99) < 65) ? OC_OK : 3'($urandom_range(7));
		if ($urandom_range(1)) begin
			r.status_zero = 8'h00;
			r.status_one = 8'h00;
			r.status_two = 8'h00;
		end else begin
			r.status_zero = 8'($urandom & $urandom);
			r.status_one = 8'($urandom & $urandom & $urandom);
			r.status_two = 8'($urandom & $urandom & $urandom);
		end
		return r;
	endfunction

	task automatic queue_request(logic [7:0] fn, logic [7:0] cnt, logic [7:0] drv,
			logic [7:0] hd, logic [15:0] cx, logic [15:0] bx, logic [2:0] oc,
			logic [7:0] s0, logic [7:0] s1, logic [7:0] s2);
		req_t r;
		r = {fn, cnt, drv, hd, cx, bx, oc, s0, s1, s2};
		pending_requests.push_back(r);
	endtask

	task automatic compare_field(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic program_geometry(cfg_t g);
		write_reg(CFG_DRIVE_COUNT, CFG_DATA_W'(g.drive_count));
		write_reg(CFG_HEAD_COUNT, CFG_DATA_W'(g.head_count));
		write_reg(CFG_TRACK_COUNT, g.track_count);
		write_reg(CFG_SPT, CFG_DATA_W'(g.sectors_per_track));
		write_reg(CFG_SECTOR_BYTES, g.sector_bytes);
		write_reg(CFG_DRIVE_TYPE, CFG_DATA_W'(g.drive_type_code));
		write_reg(CFG_PARAMS_EN, CFG_DATA_W'(g.get_params_enable));
		@(negedge clk);
		cfg_we <= 1'b0;
		geom = g;
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(negedge clk) begin : request_driver
		req_t r;
		if (arst_n && (!s_axis_tvalid || req_hs)) begin
			if (src_gap != 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				src_gap = $urandom_range(12);
				s_axis_tvalid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				r = pending_requests.pop_front();
				s_axis_tdata <= {5'd0, r.status_two, r.status_one, r.status_zero,
					r.step_outcome, r.buffer_offset, r.cyl_sector_word, r.head_number,
					r.drive_number, r.sector_count, r.function_code};
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : reply_sink
		if (arst_n) begin
			if (sink_gap != 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				sink_gap = $urandom_range(12);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		req_t       req;
		rsp_t       want, got;
		logic [4:0] pad_in;
		logic [1:0] pad_out;
		if (arst_n) begin
			req_hs <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				{pad_out, got.geom_bx, got.geom_dx, got.geom_cx, got.params_valid,
					got.carry_flag, got.transferred_count, got.status_code} = m_axis_tdata;
				if (expected_replies.size() == 0) begin
					$error("reply beat with no request outstanding");
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					compare_field("status_code", want.status_code, got.status_code);
					compare_field("transferred_count", want.transferred_count,
						got.transferred_count);
					compare_field("carry_flag", want.carry_flag, got.carry_flag);
					compare_field("params_valid", want.params_valid, got.params_valid);
					compare_field("geom_cx", want.geom_cx, got.geom_cx);
					compare_field("geom_dx", want.geom_dx, got.geom_dx);
					compare_field("geom_bx", want.geom_bx, got.geom_bx);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				{pad_in, req.status_two, req.status_one, req.status_zero, req.step_outcome,
					req.buffer_offset, req.cyl_sector_word, req.head_number,
					req.drive_number, req.sector_count, req.function_code} = s_axis_tdata;
				expected_replies.push_back(serve_request(req));
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles == STALL_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		cfg_t g;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_pct = 25;

		// default geometry: 2 drives, 2 heads, 80 cylinders, 18 sectors, 512 bytes
		queue_request(FN_STATUS, 8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_RESET, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_RESET, 8'h01, 8'h00, 8'h00, 16'h0000, 16'h0000, OC_RESETFAIL,
			8'hFF, 8'hFF, 8'hFF);
		queue_request(FN_STATUS, 8'h5A, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7,
			8'hFF, 8'hFF, 8'hFF);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0001, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		// last cylinder, last head, last sector
		queue_request(FN_READ, 8'd1, 8'd1, 8'd1, 16'h4F12, 16'h0000, OC_OK,
			8'h3F, 8'hC8, 8'hCC);
		queue_request(FN_READ, 8'd1, 8'd2, 8'd0, 16'h0001, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_READ, 8'd0, 8'd0, 8'd0, 16'h0001, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd2, 16'h0001, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h5001, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		// cylinder high bits set
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h00C1, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0000, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0013, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		// run past the end of the track
		queue_request(FN_READ, 8'd10, 8'd0, 8'd0, 16'h000A, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		// buffer ends exactly at the 64k line, then one byte short of it
		queue_request(FN_READ, 8'd2, 8'd0, 8'd0, 16'h0001, 16'hFC00, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_READ, 8'd2, 8'd0, 8'd0, 16'h0001, 16'hFBFF, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0001, 16'h0000, OC_SHORT,
			8'h00, 8'h00, 8'h00);
		// unnamed outcome code
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0001, 16'h0000, 3'd6,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0001, 16'h0000, OC_OK,
			8'h40, 8'h12, 8'h00);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0001, 16'h0000, OC_OK,
			8'h00, 8'h10, 8'h21);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0001, 16'h0000, OC_OK,
			8'hC0, 8'h00, 8'h20);
		queue_request(FN_READ, 8'd1, 8'd0, 8'd0, 16'h0001, 16'h0000, OC_OK,
			8'h50, 8'h00, 8'h00);
		// verify ignores result bytes and a short result phase
		queue_request(FN_VERIFY, 8'd18, 8'd1, 8'd0, 16'h0001, 16'hFFFF, OC_SHORT,
			8'hFF, 8'hFF, 8'hFF);
		queue_request(FN_PARAMS, 8'h00, 8'd1, 8'h00, 16'h0000, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(8'hFF, 8'h33, 8'h00, 8'h00, 16'h0000, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		queue_request(FN_STATUS, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, OC_OK,
			8'h00, 8'h00, 8'h00);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: g = '{3'd1, 2'd1, 11'd1, 6'd1, 11'd128, 8'h00, 1'b0};
				1: g = '{3'd4, 2'd2, 11'd1024, 6'd63, 11'd1024, 8'hFF, 1'b1};
				// zero heads and cylinders wrap the reported maxima
				2: g = '{3'd3, 2'd0, 11'd0, 6'd9, 11'd256, 8'h5A, 1'b1};
				default: begin
					g.drive_count = 3'($urandom_range(4, 1));
					g.head_count = 2'($urandom_range(2, 1));
					g.track_count = 11'($urandom_range(1) ? $urandom_range(100, 1) :
						$urandom_range(1024, 1));
					g.sectors_per_track = 6'($urandom_range(63, 1));
					g.sector_bytes = 11'($urandom_range(1024, 128));
					g.drive_type_code = 8'($urandom);
					g.get_params_enable = 1'($urandom_range(1));
				end
			endcase
			program_geometry(g);
			idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
			repeat (PHASE_ITEMS) pending_requests.push_back(make_request());
			if (ph == 5) begin
				while (pending_requests.size() > 200)
					@(posedge clk);
				idle_pct = 0;
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
